@@ rtl/core/dsc_pkg.sv @@
// Shared types, constants and helper functions for the countdown scoreboard.
package dsc_pkg;

    localparam int unsigned START_W      = 20;
    localparam int unsigned TICKS_W      = 8;
    localparam int unsigned SCORE_W      = 7;
    localparam int unsigned DIGIT_W      = 4;
    localparam int unsigned MUX_W        = 3;
    localparam int unsigned SEG_W        = 7;
    localparam int unsigned SEC_W        = 10;  // whole seconds left, up to 599
    localparam int unsigned Q10_W        = 6;   // seconds / 10, up to 59

    localparam int unsigned NUM_DIGITS   = 7;
    localparam int unsigned SCORE_MAX    = 99;

    localparam logic [START_W-1:0] START_LIMIT    = START_W'(599000);
    localparam logic [START_W-1:0] START_RESET    = START_W'(90000);
    localparam logic [TICKS_W-1:0] DEBOUNCE_RESET = TICKS_W'(1);

    // Reciprocal multipliers: exact floor division over the full input range.
    // ms -> s: ceil(2^30 / 1000), s -> s/60: ceil(2^16 / 60), s -> s/10: ceil(2^14 / 10)
    localparam logic [20:0] RECIP_MS   = 21'd1073742;
    localparam int unsigned SHIFT_MS   = 30;
    localparam logic [10:0] RECIP_MIN  = 11'd1093;
    localparam int unsigned SHIFT_MIN  = 16;
    localparam logic [10:0] RECIP_TEN  = 11'd1639;
    localparam int unsigned SHIFT_TEN  = 14;

    localparam int unsigned IN_TDATA_W  = 8;
    localparam int unsigned OUT_TDATA_W = 40;

    typedef enum logic [0:0] {
        CFG_START_TIME = 1'b0,
        CFG_DEBOUNCE   = 1'b1
    } t_cfg_reg;

    // Payload carried down the digit pipeline
    typedef struct packed {
        logic               active;
        logic [START_W-1:0] rem;
        logic [SEC_W-1:0]   sec;
        logic [Q10_W-1:0]   q10;
        logic [DIGIT_W-1:0] q60;
        logic [MUX_W-1:0]   mux;
        logic [SCORE_W-1:0] score_a;
        logic [SCORE_W-1:0] score_b;
        logic [DIGIT_W-1:0] a_tens;
        logic [DIGIT_W-1:0] a_ones;
        logic [DIGIT_W-1:0] b_tens;
        logic [DIGIT_W-1:0] b_ones;
        logic               expired;
    } t_stage;

    // Active-low segment pattern, blank for anything that is not a decimal digit
    function automatic logic [SEG_W-1:0] seg_pattern(input logic [DIGIT_W-1:0] d);
        logic [SEG_W-1:0] p;
        unique case (d)
            4'd0:    p = 7'h40;
            4'd1:    p = 7'h79;
            4'd2:    p = 7'h24;
            4'd3:    p = 7'h30;
            4'd4:    p = 7'h19;
            4'd5:    p = 7'h12;
            4'd6:    p = 7'h02;
            4'd7:    p = 7'h78;
            4'd8:    p = 7'h00;
            4'd9:    p = 7'h18;
            default: p = 7'h7F;
        endcase
        return p;
    endfunction

    // Tens digit of a score in 0..127 by threshold compares
    function automatic logic [DIGIT_W-1:0] score_tens(input logic [SCORE_W-1:0] s);
        logic [DIGIT_W-1:0] t;
        t = '0;
        for (int i = 1; i <= 12; i++) begin
            if (s >= SCORE_W'(i * 10)) begin
                t = DIGIT_W'(i);
            end
        end
        return t;
    endfunction

endpackage

@@ rtl/core/dsc_debounce.sv @@
// Debounce of one active-low team button plus that team's wrapping score.
module dsc_debounce #(
    parameter int unsigned SCORE_MAX = dsc_pkg::SCORE_MAX
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_raw,
    input  logic [dsc_pkg::TICKS_W-1:0] i_ticks,
    output logic [dsc_pkg::SCORE_W-1:0] o_score_next
);

    logic                        r_prev, n_prev;
    logic                        r_acc,  n_acc;
    logic [dsc_pkg::TICKS_W-1:0] r_count, n_count;
    logic [dsc_pkg::SCORE_W-1:0] r_score, n_score;
    logic [dsc_pkg::TICKS_W-1:0] w_count;

    always_comb begin
        n_prev  = r_prev;
        n_acc   = r_acc;
        n_count = r_count;
        n_score = r_score;
        w_count = (i_raw != r_prev) ? '0 : r_count;
        if (i_en) begin
            if ((w_count > i_ticks) && (r_acc != i_raw)) begin
                n_acc = i_raw;
                if (!i_raw) begin
                    n_score = (r_score >= dsc_pkg::SCORE_W'(SCORE_MAX)) ?
                              '0 : r_score + 1'b1;
                end
            end
            n_prev  = i_raw;
            n_count = (w_count != '1) ? w_count + 1'b1 : w_count;
        end
    end

    assign o_score_next = n_score;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev  <= 1'b1;
            r_acc   <= 1'b1;
            r_count <= '0;
            r_score <= '0;
        end else begin
            r_prev  <= n_prev;
            r_acc   <= n_acc;
            r_count <= n_count;
            r_score <= n_score;
        end
    end

endmodule

@@ rtl/core/debounced_score_countdown_display.sv @@
// Top level: countdown timer, debounced team scores and multiplexed digit display.
//
// Usage
//   Slave stream: one transfer per millisecond tick; tdata carries the raw
//   active-low button levels of both teams. Master stream: one transfer per
//   accepted tick with the segment pattern of the digit shown on that tick,
//   its digit index, the remaining-time digits, both scores and the expired
//   flag. Configuration: i_cfg_we writes start time (index 0, clamped to
//   599000 ms) or debounce ticks (index 1); write only while no tick is in
//   flight.
// Timing
//   Four register stages: tick state update, ms->seconds reciprocal
//   multiply, seconds->minutes/tens multiplies, digit assembly and output
//   register. Master tvalid rises once a tick has passed through all four
//   registers; throughput is one tick per cycle while the master side does
//   not stall. The ms->seconds multiply sets the longest path.
// Reset and stall
//   Synchronous active-low reset restores the register defaults, clears
//   elapsed time, scores and digits, and empties the pipeline. Each stage
//   holds while the one after it is full and stalled, so a stalled master
//   side fills the bubbles first, then s_axis_tready drops.
module debounced_score_countdown_display #(
    parameter int unsigned SCORE_MAX = dsc_pkg::SCORE_MAX
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Config write port
    input  logic                            i_cfg_we,
    input  logic [0:0]                      i_cfg_addr,
    input  logic [dsc_pkg::START_W-1:0]     i_cfg_data,
    // Tick input
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [0] button_a, [1] button_b, [7:2] zero
    input  logic [dsc_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // Display output
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [6:0] segments, [9:7] digit_select, [13:10] minutes, [16:14] seconds_tens,
    // [20:17] seconds_ones, [27:21] score_a, [34:28] score_b, [35] expired,
    // [39:36] zero
    output logic [dsc_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    // ---------------------------------------------------------------- config
    logic [dsc_pkg::START_W-1:0] r_start;
    logic [dsc_pkg::TICKS_W-1:0] r_ticks;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= dsc_pkg::START_RESET;
            r_ticks <= dsc_pkg::DEBOUNCE_RESET;
        end else if (i_cfg_we) begin
            unique case (dsc_pkg::t_cfg_reg'(i_cfg_addr))
                dsc_pkg::CFG_START_TIME:
                    r_start <= (i_cfg_data > dsc_pkg::START_LIMIT) ?
                               dsc_pkg::START_LIMIT : i_cfg_data;
                dsc_pkg::CFG_DEBOUNCE:
                    r_ticks <= i_cfg_data[dsc_pkg::TICKS_W-1:0];
                default: ;
            endcase
        end
    end

    // -------------------------------------------------------- stage handshake
    // r_v1..r_v3: pipeline stages, r_vo: output register.
    logic r_v1, r_v2, r_v3, r_vo;
    logic w_ld1, w_ld2, w_ld3, w_ldo;

    assign w_ldo         = r_v3 && (!r_vo || m_axis_tready);
    assign w_ld3         = r_v2 && (!r_v3 || w_ldo);
    assign w_ld2         = r_v1 && (!r_v2 || w_ld3);
    assign s_axis_tready = !r_v1 || w_ld2;
    assign w_ld1         = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            r_v1 <= w_ld1 || (r_v1 && !w_ld2);
            r_v2 <= w_ld2 || (r_v2 && !w_ld3);
            r_v3 <= w_ld3 || (r_v3 && !w_ldo);
            r_vo <= w_ldo || (r_vo && !m_axis_tready);
        end
    end

    // ---------------------------------------------------- stage 1: tick state
    logic [dsc_pkg::START_W-1:0] r_elapsed, n_elapsed;
    logic [dsc_pkg::MUX_W-1:0]   r_mux;
    logic                        w_active;
    logic [dsc_pkg::SCORE_W-1:0] w_score_a, w_score_b;
    dsc_pkg::t_stage             r_s1, n_s1;

    // Counting runs only while time is left; once frozen, buttons are ignored.
    assign w_active  = r_elapsed < r_start;
    assign n_elapsed = (w_active && w_ld1) ? r_elapsed + 1'b1 : r_elapsed;

    dsc_debounce #(
        .SCORE_MAX    (SCORE_MAX)
    ) u_deb_a (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (w_ld1 && w_active),
        .i_raw        (s_axis_tdata[0]),
        .i_ticks      (r_ticks),
        .o_score_next (w_score_a)
    );

    dsc_debounce #(
        .SCORE_MAX    (SCORE_MAX)
    ) u_deb_b (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (w_ld1 && w_active),
        .i_raw        (s_axis_tdata[1]),
        .i_ticks      (r_ticks),
        .o_score_next (w_score_b)
    );

    always_comb begin
        n_s1         = '0;
        n_s1.active  = w_active;
        n_s1.rem     = r_start - r_elapsed;
        n_s1.mux     = r_mux;
        n_s1.score_a = w_score_a;
        n_s1.score_b = w_score_b;
        n_s1.expired = n_elapsed >= r_start;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elapsed <= '0;
            r_mux     <= '0;
        end else if (w_ld1) begin
            r_elapsed <= n_elapsed;
            r_mux     <= (r_mux >= dsc_pkg::MUX_W'(dsc_pkg::NUM_DIGITS - 1)) ?
                         '0 : r_mux + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ld1) begin
            r_s1 <= n_s1;
        end
    end

    // ------------------------------------- stage 2: ms -> seconds, score split
    dsc_pkg::t_stage r_s2, n_s2;
    logic [40:0]     w_prod_ms;

    assign w_prod_ms = {21'd0, r_s1.rem} * {20'd0, dsc_pkg::RECIP_MS};

    always_comb begin
        n_s2        = r_s1;
        n_s2.sec    = w_prod_ms[dsc_pkg::SHIFT_MS +: dsc_pkg::SEC_W];
        n_s2.a_tens = dsc_pkg::score_tens(r_s1.score_a);
        n_s2.b_tens = dsc_pkg::score_tens(r_s1.score_b);
        n_s2.a_ones = dsc_pkg::DIGIT_W'(r_s1.score_a
                      - dsc_pkg::SCORE_W'({n_s2.a_tens, 3'b000} + {n_s2.a_tens, 1'b0}));
        n_s2.b_ones = dsc_pkg::DIGIT_W'(r_s1.score_b
                      - dsc_pkg::SCORE_W'({n_s2.b_tens, 3'b000} + {n_s2.b_tens, 1'b0}));
    end

    always_ff @(posedge i_clk) begin
        if (w_ld2) begin
            r_s2 <= n_s2;
        end
    end

    // ---------------------------------------- stage 3: seconds / 60 and / 10
    dsc_pkg::t_stage r_s3, n_s3;
    logic [20:0]     w_prod_min, w_prod_ten;

    assign w_prod_min = {11'd0, r_s2.sec} * {10'd0, dsc_pkg::RECIP_MIN};
    assign w_prod_ten = {11'd0, r_s2.sec} * {10'd0, dsc_pkg::RECIP_TEN};

    always_comb begin
        n_s3     = r_s2;
        n_s3.q60 = w_prod_min[dsc_pkg::SHIFT_MIN +: dsc_pkg::DIGIT_W];
        n_s3.q10 = w_prod_ten[dsc_pkg::SHIFT_TEN +: dsc_pkg::Q10_W];
    end

    always_ff @(posedge i_clk) begin
        if (w_ld3) begin
            r_s3 <= n_s3;
        end
    end

    // ------------------------------------- stage 4: digits and output register
    logic [dsc_pkg::DIGIT_W-1:0] r_min,  n_min;
    logic [dsc_pkg::DIGIT_W-1:0] r_tens, n_tens;
    logic [dsc_pkg::DIGIT_W-1:0] r_ones, n_ones;
    logic [dsc_pkg::DIGIT_W-1:0] w_tens_calc, w_ones_calc, w_shown;
    logic [dsc_pkg::OUT_TDATA_W-1:0] r_out;

    // tens of seconds = (s/10) mod 6, ones = s mod 10; 10 * (s/10) needs all
    // ten bits, so both addends are widened first
    assign w_tens_calc = dsc_pkg::DIGIT_W'(r_s3.q10
                         - dsc_pkg::Q10_W'({r_s3.q60, 2'b00} + {r_s3.q60, 1'b0}));
    assign w_ones_calc = dsc_pkg::DIGIT_W'(r_s3.sec
                         - ({1'b0, r_s3.q10, 3'b000} + {3'b000, r_s3.q10, 1'b0}));

    // Time digits hold their last value once the countdown is frozen.
    assign n_min  = r_s3.active ? r_s3.q60   : r_min;
    assign n_tens = r_s3.active ? w_tens_calc : r_tens;
    assign n_ones = r_s3.active ? w_ones_calc : r_ones;

    always_comb begin
        unique case (r_s3.mux)
            3'd0:    w_shown = n_ones;
            3'd1:    w_shown = n_tens;
            3'd2:    w_shown = n_min;
            3'd3:    w_shown = r_s3.a_ones;
            3'd4:    w_shown = r_s3.a_tens;
            3'd5:    w_shown = r_s3.b_ones;
            default: w_shown = r_s3.b_tens;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min  <= '0;
            r_tens <= '0;
            r_ones <= '0;
        end else if (w_ldo) begin
            r_min  <= n_min;
            r_tens <= n_tens;
            r_ones <= n_ones;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ldo) begin
            r_out <= {4'd0,
                      r_s3.expired,
                      r_s3.score_b,
                      r_s3.score_a,
                      n_ones,
                      n_tens[2:0],
                      n_min,
                      r_s3.mux,
                      dsc_pkg::seg_pattern(w_shown)};
        end
    end

    assign m_axis_tvalid = r_vo;
    assign m_axis_tdata  = r_out;

endmodule

@@ rtl/core/dsc_checker.sv @@
// Port-level checks on the countdown scoreboard, bound to the top level.
module dsc_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [dsc_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    // Stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // Pipeline is empty right after reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // Input is held off only when every stage is full and the output is stalled
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without output stall");

    // Shown digit index and time digits stay in their decimal ranges
    a_digits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[9:7] != 3'd7) && (m_axis_tdata[13:10] <= 4'd9)
                          && (m_axis_tdata[16:14] <= 3'd5) && (m_axis_tdata[20:17] <= 4'd9))
        else $error("digit out of range");

    // Scores wrap at the maximum
    a_score: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[27:21] <= 7'(dsc_pkg::SCORE_MAX))
                          && (m_axis_tdata[34:28] <= 7'(dsc_pkg::SCORE_MAX)))
        else $error("score beyond maximum");

endmodule

bind debounced_score_countdown_display dsc_checker u_dsc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
